FILE: src/arle_pkg.sv
// ----------------------------------------------------------------------------
// arle_pkg
// shared types, codes and pattern matching helpers for the response line engine
// ----------------------------------------------------------------------------
package arle_pkg;

    // item mode codes
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // command result codes
    localparam logic [1:0] RES_NONE    = 2'd0;
    localparam logic [1:0] RES_OK      = 2'd1;
    localparam logic [1:0] RES_ERROR   = 2'd2;
    localparam logic [1:0] RES_TIMEOUT = 2'd3;

    // +IPD, prefix tracking codes
    localparam logic [2:0] PREFIX_MATCHED = 3'd5;
    localparam logic [2:0] PREFIX_FAILED  = 3'd6;

    // length field phases
    localparam logic [1:0] PHASE_SKIP_ID = 2'd0;
    localparam logic [1:0] PHASE_DIGITS  = 2'd1;
    localparam logic [1:0] PHASE_DONE    = 2'd2;

    // characters
    localparam logic [7:0] CHR_NUL     = 8'h00;
    localparam logic [7:0] CHR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHR_COMMA   = 8'h2C;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_NINE    = 8'h39;

    localparam logic [15:0] LENGTH_SAT = 16'hFFFF;

    // patterns, index 0 first, padded with zero
    typedef logic [0:7][7:0] pat_t;

    localparam pat_t PAT_CONNECT = {"C", "O", "N", "N", "E", "C", "T", 8'h00};
    localparam pat_t PAT_CLOSED  = {"C", "L", "O", "S", "E", "D", 8'h00, 8'h00};
    localparam pat_t PAT_OK      = {"O", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam pat_t PAT_ERROR   = {"E", "R", "R", "O", "R", 8'h00, 8'h00, 8'h00};
    localparam pat_t PAT_IPD     = {"+", "I", "P", "D", ",", 8'h00, 8'h00, 8'h00};

    localparam logic [3:0] LEN_CONNECT = 4'd7;
    localparam logic [3:0] LEN_CLOSED  = 4'd6;
    localparam logic [3:0] LEN_OK      = 4'd2;
    localparam logic [3:0] LEN_ERROR   = 4'd5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  rx_byte;
        logic [15:0] timeout_ticks;
    } in_item_t;

    typedef struct packed {
        logic        line_end;
        logic [1:0]  cmd_result;
        logic        busy_res;
        logic        start_accepted;
        logic        client_connected;
        logic        ipd_line;
        logic [15:0] ipd_length;
    } out_item_t;

    // what the line scanner knows about the line so far
    typedef struct packed {
        logic        connect_seen;
        logic        closed_seen;
        logic        ok_seen;
        logic        error_seen;
        logic        ipd_matched;
        logic [15:0] ipd_length;
    } line_status_t;

    // longest prefix of pat that is a suffix of pat[0..prog-1] followed by c
    function automatic logic [3:0] match_next(pat_t pat, logic [2:0] prog, logic [7:0] c);
        logic [3:0] res;
        logic       same;
        res = 4'd0;
        for (int k = 1; k <= 8; k++)
        begin
            if (k <= int'(prog) + 1)
            begin
                same = (pat[k-1] == c);
                for (int i = 0; i < 7; i++)
                begin
                    if (i < k - 1)
                    begin
                        if (pat[i] != pat[int'(prog) + 1 - k + i])
                            same = 1'b0;
                    end
                end
                if (same)
                    res = 4'(k);
            end
        end
        return res;
    endfunction

endpackage

FILE: src/arle_line_scan.sv
// ----------------------------------------------------------------------------
// arle_line_scan
// per-line incremental matchers, +IPD prefix tracker and length field parser
// ----------------------------------------------------------------------------
module arle_line_scan
    import arle_pkg::*;
#(
    parameter int LINE_MAX = 128
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_take,
    input  logic [7:0]   rx_byte,
    input  logic         line_clear,
    output line_status_t status
);

    localparam logic [7:0] COUNT_LIMIT = 8'(LINE_MAX - 1);

    logic [7:0]  line_count_reg, line_count_next;
    logic        text_ended_reg, text_ended_next;
    logic [2:0]  conn_prog_reg, conn_prog_next;
    logic [2:0]  clsd_prog_reg, clsd_prog_next;
    logic [1:0]  ok_prog_reg, ok_prog_next;
    logic [2:0]  err_prog_reg, err_prog_next;
    logic [3:0]  found_reg, found_next;
    logic [2:0]  prefix_reg, prefix_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] length_reg, length_next;

    logic [3:0]  n_conn, n_clsd, n_ok, n_err;
    logic [19:0] len_ext, len_prod;
    logic        take;

    assign take     = byte_take && (line_count_reg < COUNT_LIMIT);
    assign n_conn   = match_next(PAT_CONNECT, conn_prog_reg, rx_byte);
    assign n_clsd   = match_next(PAT_CLOSED, clsd_prog_reg, rx_byte);
    assign n_ok     = match_next(PAT_OK, {1'b0, ok_prog_reg}, rx_byte);
    assign n_err    = match_next(PAT_ERROR, err_prog_reg, rx_byte);
    assign len_ext  = {4'd0, length_reg};
    assign len_prod = (len_ext << 3) + (len_ext << 1) + {16'd0, 4'(rx_byte - CHR_ZERO)};

    always_comb
    begin
        line_count_next = line_count_reg;
        text_ended_next = text_ended_reg;
        conn_prog_next  = conn_prog_reg;
        clsd_prog_next  = clsd_prog_reg;
        ok_prog_next    = ok_prog_reg;
        err_prog_next   = err_prog_reg;
        found_next      = found_reg;
        prefix_next     = prefix_reg;
        phase_next      = phase_reg;
        length_next     = length_reg;

        if (take)
        begin
            line_count_next = line_count_reg + 8'd1;
            if (!text_ended_reg)
            begin
                if (rx_byte == CHR_NUL)
                begin
                    text_ended_next = 1'b1;
                end
                else
                begin
                    if (n_conn >= LEN_CONNECT)
                    begin
                        found_next[0]  = 1'b1;
                        conn_prog_next = 3'd0;
                    end
                    else
                        conn_prog_next = n_conn[2:0];

                    if (n_clsd >= LEN_CLOSED)
                    begin
                        found_next[1]  = 1'b1;
                        clsd_prog_next = 3'd0;
                    end
                    else
                        clsd_prog_next = n_clsd[2:0];

                    if (n_ok >= LEN_OK)
                    begin
                        found_next[2] = 1'b1;
                        ok_prog_next  = 2'd0;
                    end
                    else
                        ok_prog_next = n_ok[1:0];

                    if (n_err >= LEN_ERROR)
                    begin
                        found_next[3] = 1'b1;
                        err_prog_next = 3'd0;
                    end
                    else
                        err_prog_next = n_err[2:0];

                    if (prefix_reg == PREFIX_MATCHED)
                    begin
                        if (phase_reg == PHASE_SKIP_ID)
                        begin
                            if (rx_byte == CHR_COMMA)
                                phase_next = PHASE_DIGITS;
                        end
                        else if (phase_reg == PHASE_DIGITS)
                        begin
                            if (rx_byte inside {[CHR_ZERO:CHR_NINE]})
                            begin
                                if (len_prod > {4'd0, LENGTH_SAT})
                                    length_next = LENGTH_SAT;
                                else
                                    length_next = len_prod[15:0];
                            end
                            else
                                phase_next = PHASE_DONE;
                        end
                    end
                    else if (prefix_reg < PREFIX_MATCHED)
                    begin
                        if (rx_byte == PAT_IPD[prefix_reg])
                            prefix_next = prefix_reg + 3'd1;
                        else
                            prefix_next = PREFIX_FAILED;
                    end
                end
            end
        end

        // newline or accepted start drops the line
        if (line_clear)
        begin
            line_count_next = 8'd0;
            text_ended_next = 1'b0;
            conn_prog_next  = 3'd0;
            clsd_prog_next  = 3'd0;
            ok_prog_next    = 2'd0;
            err_prog_next   = 3'd0;
            found_next      = 4'd0;
            prefix_next     = 3'd0;
            phase_next      = PHASE_SKIP_ID;
            length_next     = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= 8'd0;
            text_ended_reg <= 1'b0;
            conn_prog_reg  <= 3'd0;
            clsd_prog_reg  <= 3'd0;
            ok_prog_reg    <= 2'd0;
            err_prog_reg   <= 3'd0;
            found_reg      <= 4'd0;
            prefix_reg     <= 3'd0;
            phase_reg      <= PHASE_SKIP_ID;
            length_reg     <= 16'd0;
        end
        else
        begin
            line_count_reg <= line_count_next;
            text_ended_reg <= text_ended_next;
            conn_prog_reg  <= conn_prog_next;
            clsd_prog_reg  <= clsd_prog_next;
            ok_prog_reg    <= ok_prog_next;
            err_prog_reg   <= err_prog_next;
            found_reg      <= found_next;
            prefix_reg     <= prefix_next;
            phase_reg      <= phase_next;
            length_reg     <= length_next;
        end
    end

    // a newline can neither complete a pattern nor add a digit, so the
    // state before it is what judges the line
    assign status.connect_seen = found_reg[0];
    assign status.closed_seen  = found_reg[1];
    assign status.ok_seen      = found_reg[2];
    assign status.error_seen   = found_reg[3];
    assign status.ipd_matched  = (prefix_reg == PREFIX_MATCHED);
    assign status.ipd_length   = length_reg;

endmodule

FILE: src/at_response_line_engine_top.sv
// ----------------------------------------------------------------------------
// at_response_line_engine_top
// modem response line engine: line matching, command wait and timeout
// ----------------------------------------------------------------------------
// usage
//   item channel (item_valid / item_stall / item): one transfer per modem
//   byte, command start or 1 ms tick, selected by item.mode
//   result channel (result_valid / result_stall / result): exactly one
//   transfer per accepted item, in order
//   the result is registered into the result queue at the item transfer;
//   throughput is one item per cycle unless item_stall is high, set by the
//   single pass of the byte matchers and the command logic before the queue
//   the result side is a two-entry queue, so an item is still taken while
//   one finished result waits; item_stall rises only when both entries are
//   full, and it comes from registers only
//   while the receiver stalls, the head result holds steady
//   reset clears the queue, the wait state, the timer, the client flag and
//   all per-line matching state
//   lines are judged on newline; only the first LINE_MAX-1 bytes of a line
//   are matched
// ----------------------------------------------------------------------------
module at_response_line_engine_top
    import arle_pkg::*;
#(
    parameter int LINE_MAX = 128
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    // command state
    logic        waiting_reg, waiting_next;
    logic [15:0] ticks_reg, ticks_next;
    logic        connected_reg, connected_next;

    // result queue
    out_item_t   head_reg, tail_reg;
    logic [1:0]  count_reg, count_next;

    line_status_t line_st;
    out_item_t    res_new;
    logic         accept;
    logic         pop;
    logic         newline;
    logic         start_ok;

    assign accept   = item_valid && !item_stall;
    assign pop      = result_valid && !result_stall;
    assign newline  = (item.mode == MODE_BYTE) && (item.rx_byte == CHR_NEWLINE);
    assign start_ok = (item.mode == MODE_START) && !waiting_reg;

    arle_line_scan #(
        .LINE_MAX (LINE_MAX)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_take  (accept && (item.mode == MODE_BYTE)),
        .rx_byte    (item.rx_byte),
        .line_clear (accept && (newline || start_ok)),
        .status     (line_st)
    );

    // command wait, timer and line judgment
    always_comb
    begin
        waiting_next   = waiting_reg;
        ticks_next     = ticks_reg;
        connected_next = connected_reg;
        res_new        = '0;

        case (item.mode)
            MODE_BYTE:
            begin
                if (newline)
                begin
                    res_new.line_end = 1'b1;
                    if (line_st.connect_seen)
                        connected_next = 1'b1;
                    else if (line_st.closed_seen)
                        connected_next = 1'b0;

                    if (line_st.ipd_matched)
                    begin
                        res_new.ipd_line   = 1'b1;
                        res_new.ipd_length = line_st.ipd_length;
                    end
                    else if (waiting_reg)
                    begin
                        // ok has priority over error
                        if (line_st.ok_seen)
                        begin
                            res_new.cmd_result = RES_OK;
                            waiting_next       = 1'b0;
                        end
                        else if (line_st.error_seen)
                        begin
                            res_new.cmd_result = RES_ERROR;
                            waiting_next       = 1'b0;
                        end
                    end
                end
            end
            MODE_START:
            begin
                if (start_ok)
                begin
                    waiting_next           = 1'b1;
                    ticks_next             = item.timeout_ticks;
                    res_new.start_accepted = 1'b1;
                end
            end
            MODE_TICK:
            begin
                if (waiting_reg)
                begin
                    if (ticks_reg <= 16'd1)
                    begin
                        ticks_next         = 16'd0;
                        waiting_next       = 1'b0;
                        res_new.cmd_result = RES_TIMEOUT;
                    end
                    else
                        ticks_next = ticks_reg - 16'd1;
                end
            end
            default:
            begin
                // unused mode: result shows only state
            end
        endcase

        res_new.busy_res         = waiting_next;
        res_new.client_connected = connected_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg   <= 1'b0;
            ticks_reg     <= 16'd0;
            connected_reg <= 1'b0;
        end
        else if (accept)
        begin
            waiting_reg   <= waiting_next;
            ticks_reg     <= ticks_next;
            connected_reg <= connected_next;
        end
    end

    // two-entry result queue
    assign item_stall   = (count_reg == 2'd2);
    assign result_valid = (count_reg != 2'd0);
    assign result       = head_reg;

    always_comb
    begin
        count_next = count_reg;
        if (accept && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !accept)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (count_reg == 2'd0)
        begin
            if (accept)
                head_reg <= res_new;
        end
        else if (pop)
        begin
            if (count_reg == 2'd2)
                head_reg <= tail_reg;
            else if (accept)
                head_reg <= res_new;
        end

        if (accept && !pop && (count_reg == 2'd1))
            tail_reg <= res_new;
    end

endmodule

FILE: src/arle_checker.sv
// ----------------------------------------------------------------------------
// arle_checker
// port-level checks on the result channel of the response line engine
// ----------------------------------------------------------------------------
module arle_checker
    import arle_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      result_valid,
    input logic      result_stall,
    input out_item_t result
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // an accepted start leaves the engine busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.start_accepted |->
            result.busy_res && (result.cmd_result == RES_NONE))
        else $error("accepted start without busy");

    // a finished command leaves the engine idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.cmd_result != RES_NONE) |-> !result.busy_res)
        else $error("command result while still busy");

    // ipd report only on a closed line, length zero otherwise
    a_ipd: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !(result.ipd_line && result.line_end) |->
            !result.ipd_line && (result.ipd_length == 16'd0))
        else $error("ipd report outside a closed ipd line");

endmodule

bind at_response_line_engine_top arle_checker u_arle_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the modem response line engine: a cycle-free
// predictor tracks line matching, command wait and tick countdown, and every
// result transfer is compared field by field with the predicted response
// ----------------------------------------------------------------------------
module testbench;
    import arle_pkg::*;

    localparam int LINE_MAX     = 128;
    localparam int ITEMS_RANDOM = 1750;
    localparam int HOLD_CYCLES  = 250;
    localparam int TAIL_CYCLES  = 12;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_REPORTS  = 100;

    // mode value the block has no use for
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // index of each tracked word
    localparam int WORD_CONNECT = 0;
    localparam int WORD_CLOSED  = 1;
    localparam int WORD_OK      = 2;
    localparam int WORD_ERROR   = 3;
    localparam int WORD_IPD     = 4;

    // dut ports, all inputs known from time zero
    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    // predicted responses, oldest first
    out_item_t predicted_results[$];
    out_item_t want_result;

    // predictor copy of the engine state
    bit          cmd_waiting;
    logic [15:0] tick_budget;
    int          line_len;
    bit          text_hidden;
    int unsigned word_prog[4];
    bit          word_seen[4];
    logic [2:0]  ipd_prog;
    logic [1:0]  len_phase;
    logic [15:0] len_value;
    bit          client_up;

    // sender pacing
    bit valid_high = 1'b0;
    bit gaps_on    = 1'b1;
    int burst_left = 0;

    // receiver pacing; hold_req is bumped by the tests, the stall process
    // notices the change and holds off for HOLD_CYCLES on its own count
    int hold_req    = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int stall_style = 0;
    int style_left  = 0;

    // bookkeeping
    int cycle_count = 0;
    int fail_count  = 0;
    int items_sent  = 0;
    int n_lines     = 0;
    int n_ipd       = 0;
    int n_ok        = 0;
    int n_err       = 0;
    int n_tmo       = 0;
    int n_starts    = 0;
    int n_rejected  = 0;
    int n_results   = 0;

    byte unsigned line_buf[$];

    at_response_line_engine_top #(
        .LINE_MAX(LINE_MAX)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic string word_text(int w);
        case (w)
            WORD_CONNECT: return "CONNECT";
            WORD_CLOSED:  return "CLOSED";
            WORD_OK:      return "OK";
            WORD_ERROR:   return "ERROR";
            default:      return "+IPD,";
        endcase
    endfunction

    // new progress on a word: the longest head of the word that ends the
    // text seen so far (head of length prog) extended by c
    function automatic int unsigned advance_match(string pat, int unsigned prog,
                                                  byte unsigned c);
        byte unsigned cand [0:7];
        int unsigned  best;
        int unsigned  i;
        int unsigned  k;
        bit           same;
        if (prog >= pat.len())
            prog = 0;
        for (i = 0; i < prog; i++)
            cand[i] = pat[i];
        cand[prog] = c;
        best = 0;
        for (k = 1; k <= prog + 1; k++)
        begin
            same = 1'b1;
            for (i = 0; i < k; i++)
                if (cand[prog + 1 - k + i] != pat[i])
                    same = 1'b0;
            if (same)
                best = k;
        end
        return best;
    endfunction

    function automatic void clear_line();
        line_len    = 0;
        text_hidden = 1'b0;
        for (int w = 0; w < 4; w++)
        begin
            word_prog[w] = 0;
            word_seen[w] = 1'b0;
        end
        ipd_prog  = '0;
        len_phase = PHASE_SKIP_ID;
        len_value = '0;
    endfunction

    function automatic void reset_model();
        cmd_waiting = 1'b0;
        tick_budget = '0;
        client_up   = 1'b0;
        clear_line();
    endfunction

    // one visible character of the current line
    function automatic void scan_char(byte unsigned c);
        int unsigned n;
        int unsigned acc;
        string       tag;
        tag = word_text(WORD_IPD);
        if (text_hidden)
            return;
        if (c == CHR_NUL)
        begin
            text_hidden = 1'b1;
            return;
        end
        for (int w = 0; w < 4; w++)
        begin
            n = advance_match(word_text(w), word_prog[w], c);
            if (n >= word_text(w).len())
            begin
                word_seen[w] = 1'b1;
                n = 0;
            end
            word_prog[w] = n;
        end
        if (ipd_prog == PREFIX_MATCHED)
        begin
            if (len_phase == PHASE_SKIP_ID)
            begin
                if (c == CHR_COMMA)
                    len_phase = PHASE_DIGITS;
            end
            else if (len_phase == PHASE_DIGITS)
            begin
                if (c >= CHR_ZERO && c <= CHR_NINE)
                begin
                    acc = int'(len_value) * 10 + int'(c - CHR_ZERO);
                    len_value = (acc > 65535) ? LENGTH_SAT : acc[15:0];
                end
                else
                    len_phase = PHASE_DONE;
            end
        end
        else if (ipd_prog < PREFIX_MATCHED)
        begin
            if (c == tag[ipd_prog])
                ipd_prog = ipd_prog + 3'd1;
            else
                ipd_prog = PREFIX_FAILED;
        end
    endfunction

    function automatic out_item_t predict_response(in_item_t it);
        out_item_t r;
        r = '0;
        case (it.mode)
            MODE_BYTE:
            begin
                // bytes past the line limit are not scanned
                if (line_len < LINE_MAX - 1)
                begin
                    line_len++;
                    scan_char(it.rx_byte);
                end
                if (it.rx_byte == CHR_NEWLINE)
                begin
                    r.line_end = 1'b1;
                    if (word_seen[WORD_CONNECT])
                        client_up = 1'b1;
                    else if (word_seen[WORD_CLOSED])
                        client_up = 1'b0;
                    // an ipd line never completes a command
                    if (ipd_prog == PREFIX_MATCHED)
                    begin
                        r.ipd_line   = 1'b1;
                        r.ipd_length = len_value;
                    end
                    else if (cmd_waiting)
                    begin
                        if (word_seen[WORD_OK])
                        begin
                            r.cmd_result = RES_OK;
                            cmd_waiting  = 1'b0;
                        end
                        else if (word_seen[WORD_ERROR])
                        begin
                            r.cmd_result = RES_ERROR;
                            cmd_waiting  = 1'b0;
                        end
                    end
                    clear_line();
                end
            end
            MODE_START:
            begin
                if (!cmd_waiting)
                begin
                    cmd_waiting      = 1'b1;
                    tick_budget      = it.timeout_ticks;
                    r.start_accepted = 1'b1;
                    clear_line();
                end
            end
            MODE_TICK:
            begin
                if (cmd_waiting)
                begin
                    // a zero budget expires on the first tick as well
                    if (tick_budget <= 16'd1)
                    begin
                        tick_budget  = '0;
                        cmd_waiting  = 1'b0;
                        r.cmd_result = RES_TIMEOUT;
                    end
                    else
                        tick_budget = tick_budget - 16'd1;
                end
            end
            default: ;
        endcase
        r.busy_res         = cmd_waiting;
        r.client_connected = client_up;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    // offer one item, hold it until the transfer, then predict its response
    task automatic drive_item(in_item_t it);
        int        gap;
        out_item_t r;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                if (valid_high)
                begin
                    item_valid <= 1'b0;
                    valid_high = 1'b0;
                end
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left != 0)
            burst_left--;
        item       <= it;
        item_valid <= 1'b1;
        valid_high = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        r = predict_response(it);
        predicted_results.push_back(r);
        items_sent++;
        if (r.line_end)
            n_lines++;
        if (r.ipd_line)
            n_ipd++;
        if (r.start_accepted)
            n_starts++;
        if (it.mode == MODE_START && !r.start_accepted)
            n_rejected++;
        case (r.cmd_result)
            RES_OK:      n_ok++;
            RES_ERROR:   n_err++;
            RES_TIMEOUT: n_tmo++;
            default: ;
        endcase
    endtask

    // fields the mode does not use still carry random bits
    task automatic send_byte(byte unsigned c);
        in_item_t it;
        it.mode          = MODE_BYTE;
        it.rx_byte       = c;
        it.timeout_ticks = 16'($urandom);
        drive_item(it);
    endtask

    task automatic send_start(logic [15:0] t);
        in_item_t it;
        it.mode          = MODE_START;
        it.rx_byte       = 8'($urandom);
        it.timeout_ticks = t;
        drive_item(it);
    endtask

    task automatic send_tick();
        in_item_t it;
        it.mode          = MODE_TICK;
        it.rx_byte       = 8'($urandom);
        it.timeout_ticks = 16'($urandom);
        drive_item(it);
    endtask

    task automatic send_unused();
        in_item_t it;
        it.mode          = MODE_UNUSED;
        it.rx_byte       = 8'($urandom);
        it.timeout_ticks = 16'($urandom);
        drive_item(it);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // drop valid and pause until every predicted response has come back
    task automatic wait_for_drain();
        if (valid_high)
        begin
            item_valid <= 1'b0;
            valid_high = 1'b0;
        end
        do
            @(posedge clk);
        while (predicted_results.size() != 0);
    endtask

    function automatic logic [15:0] pick_timeout();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(1, 25));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // line builder
    // ------------------------------------------------------------------

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void add_noise(int n);
        for (int i = 0; i < n; i++)
            line_buf.push_back(8'($urandom_range(32, 126)));
    endfunction

    // well formed modem lines with random content, plus broken ones
    function automatic void build_line();
        line_buf.delete();
        if ($urandom_range(0, 3) == 0)
            add_noise($urandom_range(1, 4));
        case ($urandom_range(0, 15))
            0, 1: add_text("OK");
            2:    add_text("ERROR");
            3:
            begin
                // both words, ok takes priority
                add_text("ERROR");
                add_noise($urandom_range(0, 3));
                add_text("OK");
            end
            4:    add_text($urandom_range(0, 1) ? "0,CONNECT" : "CONNECT");
            5:    add_text($urandom_range(0, 1) ? "1,CLOSED" : "CLOSED");
            6:
            begin
                add_text("CLOSED ");
                add_text("CONNECT");
            end
            7, 8:
            begin
                // ipd header: optional link id, length field, data
                add_text("+IPD,");
                if ($urandom_range(0, 3) != 0)
                    add_text($sformatf("%0d,", $urandom_range(0, 4)));
                case ($urandom_range(0, 5))
                    0:       add_text("65535");
                    1:       add_text($sformatf("%0d", $urandom_range(65536, 9999999)));
                    2:       ;
                    3:       add_text("007");
                    default: add_text($sformatf("%0d", $urandom_range(0, 2048)));
                endcase
                if ($urandom_range(0, 3) != 0)
                    add_text(":");
                add_noise($urandom_range(0, 6));
                case ($urandom_range(0, 5))
                    0:       add_text("OK");
                    1:       add_text("CONNECT");
                    default: ;
                endcase
            end
            9:
            begin
                // near misses of the ipd prefix, and an ipd header with no length field
                case ($urandom_range(0, 3))
                    0:       add_text("+IPD");
                    1:       add_text("+IP,1,5");
                    2:       add_text(" +IPD,1,5");
                    default: add_text("+IPD,7");
                endcase
            end
            10:
            begin
                // overlapping and partial words
                case ($urandom_range(0, 6))
                    0:       add_text("CONNECCONNECT");
                    1:       add_text("OOK");
                    2:       add_text("ERRERROR");
                    3:       add_text("CLOSECLOSED");
                    4:       add_text("EROR");
                    5:       add_text("CONNEC");
                    default: add_text("CCLOSED");
                endcase
            end
            11:
            begin
                // zero byte hides whatever follows
                if ($urandom_range(0, 1))
                    add_text("OK");
                line_buf.push_back(CHR_NUL);
                add_text($urandom_range(0, 1) ? "ERROR" : "CONNECT");
            end
            12:
            begin
                for (int i = $urandom_range(1, 20); i > 0; i--)
                    line_buf.push_back(8'($urandom_range(0, 255)));
            end
            13:
            begin
                // overlong line; the word may straddle the line limit
                if ($urandom_range(0, 3) == 0)
                    add_noise($urandom_range(118, 135));
                case ($urandom_range(0, 2))
                    0:       add_text("OK");
                    1:       add_text("CONNECT");
                    default: add_text("ERROR");
                endcase
            end
            14: ;
            default: add_text($urandom_range(0, 1) ? "busy p..." : "ready");
        endcase
        if ($urandom_range(0, 2) == 0)
            add_text("\r");
        line_buf.push_back(CHR_NEWLINE);
    endfunction

    // send one line; now and then a tick, start or unused item cuts in
    task automatic send_random_line();
        int pick;
        build_line();
        foreach (line_buf[i])
        begin
            pick = $urandom_range(0, 99);
            if (pick == 0)
                send_start(pick_timeout());
            else if (pick < 3)
                send_tick();
            else if (pick == 3)
                send_unused();
            send_byte(line_buf[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic run_directed();
        send_start(16'hFFFF);      // largest budget
        send_text("OK\n");         // completes with ok
        send_start(16'h0000);      // zero budget
        send_start(16'h1234);      // refused while busy
        send_tick();               // zero budget expires at once
        send_tick();               // tick while idle
        send_unused();             // unused mode
        send_start(16'd2);
        send_tick();
        send_byte(8'hFF);
        send_text("ERROR\n");      // completes with error
        send_start(16'd3);
        send_text("O");
        send_byte(CHR_NUL);        // ok is cut by the zero byte
        send_text("K\n");
        send_tick();
        send_tick();
        send_tick();               // times out
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic run_backpressure();
        int first;
        first = items_sent;
        hold_req <= hold_req + 1;
        gaps_on = 1'b0;
        while (items_sent < first + 90)
            send_random_line();
        gaps_on = 1'b1;
    endtask

    task automatic run_random_traffic();
        int stop_at;
        int next_drain;
        int hold_at;
        bit hold_done;
        stop_at    = items_sent + ITEMS_RANDOM;
        next_drain = items_sent + $urandom_range(200, 400);
        hold_at    = items_sent + ITEMS_RANDOM / 2;
        hold_done  = 1'b0;
        while (items_sent < stop_at)
        begin
            // between lines: command starts and tick runs
            if (!cmd_waiting && $urandom_range(0, 1))
                send_start(pick_timeout());
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 30)) send_tick();
            else if ($urandom_range(0, 3) == 0)
                send_tick();
            send_random_line();
            if (!hold_done && items_sent >= hold_at)
            begin
                hold_req <= hold_req + 1;
                hold_done = 1'b1;
            end
            if (items_sent >= next_drain)
            begin
                wait_for_drain();
                next_drain = items_sent + $urandom_range(200, 400);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // receiver stall pattern
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (hold_req != hold_served)
        begin
            hold_served = hold_req;
            hold_left   = HOLD_CYCLES;
        end
        // styles: none, light, heavy, alternate
        if (style_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(10, 80);
        end
        else
            style_left--;
        if (hold_left != 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            case (stall_style)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 4) == 0);
                2:       result_stall <= ($urandom_range(0, 9) < 7);
                default: result_stall <= ~result_stall;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result check
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            n_results++;
            if (predicted_results.size() == 0)
                report_mismatch("result with nothing pending", result, 0);
            else
            begin
                want_result = predicted_results.pop_front();
                if (result.line_end !== want_result.line_end)
                    report_mismatch("line_end", result.line_end, want_result.line_end);
                if (result.cmd_result !== want_result.cmd_result)
                    report_mismatch("cmd_result", result.cmd_result, want_result.cmd_result);
                if (result.busy_res !== want_result.busy_res)
                    report_mismatch("busy_res", result.busy_res, want_result.busy_res);
                if (result.start_accepted !== want_result.start_accepted)
                    report_mismatch("start_accepted", result.start_accepted,
                                    want_result.start_accepted);
                if (result.client_connected !== want_result.client_connected)
                    report_mismatch("client_connected", result.client_connected,
                                    want_result.client_connected);
                if (result.ipd_line !== want_result.ipd_line)
                    report_mismatch("ipd_line", result.ipd_line, want_result.ipd_line);
                if (result.ipd_length !== want_result.ipd_length)
                    report_mismatch("ipd_length", result.ipd_length, want_result.ipd_length);
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses pending",
                     cycle_count, predicted_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        reset_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_for_drain();
        run_backpressure();
        wait_for_drain();
        run_random_traffic();
        wait_for_drain();

        // late or extra transfers show up as results with nothing pending
        repeat (TAIL_CYCLES) @(posedge clk);
        if (predicted_results.size() != 0)
            report_mismatch("responses left over", predicted_results.size(), 0);

        $display("covered %0d items and %0d lines (%0d +IPD), %0d starts taken, %0d refused",
                 items_sent, n_lines, n_ipd, n_starts, n_rejected);
        $display("command outcomes: %0d ok, %0d error, %0d timeout; %0d responses checked",
                 n_ok, n_err, n_tmo, n_results);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
